// ===== rtl/lecs_pkg.sv =====
// Shared types and constants for the LED driver latch-enable command serializer.
// No dependencies; imported by every module of the block.
package lecs_pkg;

    localparam int WORD_BITS  = 16;
    localparam int BEAT_W     = 4;   // index of a clock inside one burst
    localparam int CL_W       = 5;   // chain_length register width
    localparam int FUNC_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_DATA   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REG1   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REG2   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REG3   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_VSYNC  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_PREACT = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SRESET = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG1_WORD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG2_WORD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG3_WORD    = 2'd3;

    localparam logic [CL_W-1:0]      CHAIN_LENGTH_RST = 5'd1;
    localparam logic [WORD_BITS-1:0] REG1_WORD_RST    = 16'h0FEB;
    localparam logic [WORD_BITS-1:0] REG2_WORD_RST    = 16'h0400;
    localparam logic [WORD_BITS-1:0] REG3_WORD_RST    = 16'h0000;

    // final beat index of each burst (clock count - 1)
    localparam logic [BEAT_W-1:0] WORD_LAST_IDX   = 4'd15;
    localparam logic [BEAT_W-1:0] VSYNC_LAST_IDX  = 4'd1;
    localparam logic [BEAT_W-1:0] PREACT_LAST_IDX = 4'd13;
    localparam logic [BEAT_W-1:0] SRESET_LAST_IDX = 4'd9;

    // first beat with LE high on the last chip: 16 minus LE clock count
    localparam logic [BEAT_W-1:0] LE_START_DATA = 4'd15;  // 1 clock
    localparam logic [BEAT_W-1:0] LE_START_REG1 = 4'd12;
    localparam logic [BEAT_W-1:0] LE_START_REG2 = 4'd8;
    localparam logic [BEAT_W-1:0] LE_START_REG3 = 4'd0;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [BEAT_W-1:0]    last_idx;
        logic [BEAT_W-1:0]    le_start;
        logic                 le_en;
    } desc_t;

endpackage

// ===== rtl/lecs_front.sv =====
// Front end: accepts commands, tracks the chip position in the chain and
// turns each command into a burst descriptor. Depends on lecs_pkg.
module lecs_front #(
    parameter int CHAIN_MAX = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lecs_pkg::FUNC_W-1:0]    s_func,
    input  logic [lecs_pkg::WORD_BITS-1:0] s_word,
    input  logic [lecs_pkg::CL_W-1:0]      chain_length,
    input  logic [lecs_pkg::WORD_BITS-1:0] reg1_word,
    input  logic [lecs_pkg::WORD_BITS-1:0] reg2_word,
    input  logic [lecs_pkg::WORD_BITS-1:0] reg3_word,
    input  logic                           q_full,
    output logic                           q_push,
    output lecs_pkg::desc_t                q_desc
);
    import lecs_pkg::*;

    localparam int IDX_W = (CHAIN_MAX > 1) ? $clog2(CHAIN_MAX) : 1;
    localparam int CMP_W = ((IDX_W > CL_W) ? IDX_W : CL_W) + 1;
    localparam logic [CMP_W-1:0] CHAIN_MAX_C = CMP_W'(CHAIN_MAX);

    logic [IDX_W-1:0] chip_idx_reg;
    logic [IDX_W-1:0] chip_idx_next;
    logic [CMP_W-1:0] cl_ext;
    logic [CMP_W-1:0] eff_m1;
    logic             last_chip;
    logic             accept;
    logic             is_word;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (s_func != FUNC_UNDEF);
    assign is_word = s_func inside {FUNC_DATA, FUNC_REG1, FUNC_REG2, FUNC_REG3};

    // effective chain length minus one, clamped to 1..CHAIN_MAX
    assign cl_ext = CMP_W'(chain_length);
    always_comb begin
        if (cl_ext == '0) begin
            eff_m1 = '0;
        end else if (cl_ext > CHAIN_MAX_C) begin
            eff_m1 = CHAIN_MAX_C - CMP_W'(1);
        end else begin
            eff_m1 = cl_ext - CMP_W'(1);
        end
    end

    assign last_chip = (CMP_W'(chip_idx_reg) >= eff_m1);

    always_comb begin
        q_desc        = '0;
        chip_idx_next = chip_idx_reg;
        case (s_func)
            FUNC_DATA: begin
                q_desc.word     = s_word;
                q_desc.le_start = LE_START_DATA;
            end
            FUNC_REG1: begin
                q_desc.word     = reg1_word;
                q_desc.le_start = LE_START_REG1;
            end
            FUNC_REG2: begin
                q_desc.word     = reg2_word;
                q_desc.le_start = LE_START_REG2;
            end
            FUNC_REG3: begin
                q_desc.word     = reg3_word;
                q_desc.le_start = LE_START_REG3;
            end
            FUNC_VSYNC: begin
                q_desc.last_idx = VSYNC_LAST_IDX;
            end
            FUNC_PREACT: begin
                q_desc.last_idx = PREACT_LAST_IDX;
            end
            FUNC_SRESET: begin
                q_desc.last_idx = SRESET_LAST_IDX;
            end
            default: begin
            end
        endcase
        if (is_word) begin
            q_desc.last_idx = WORD_LAST_IDX;
            q_desc.le_en    = last_chip;
            chip_idx_next   = last_chip ? '0 : chip_idx_reg + IDX_W'(1);
        end else if (s_func != FUNC_UNDEF) begin
            // framing command: LE high, SDI low for the whole burst
            q_desc.le_en  = 1'b1;
            chip_idx_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_idx_reg <= '0;
        end else if (accept) begin
            chip_idx_reg <= chip_idx_next;
        end
    end

endmodule

// ===== rtl/lecs_queue.sv =====
// Short descriptor queue between the front end and the bit sequencer.
// Depends on lecs_pkg for the descriptor type and depth.
module lecs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lecs_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output lecs_pkg::desc_t head
);
    import lecs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    desc_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");

endmodule

// ===== rtl/lecs_back.sv =====
// Bit sequencer: plays each descriptor out as a burst of SDI/LE beats into
// a registered output stage. Depends on lecs_pkg.
module lecs_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_not_empty,
    input  lecs_pkg::desc_t q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_sdi,
    output logic            m_le,
    output logic            m_last
);
    import lecs_pkg::*;

    logic [BEAT_W-1:0] beat_reg;
    logic              m_valid_reg;
    logic              m_sdi_reg;
    logic              m_le_reg;
    logic              m_last_reg;
    logic              produce;
    logic              beat_sdi;
    logic              beat_le;
    logic              beat_last;

    // MSB first: bit 15 - beat
    assign beat_sdi  = q_head.word[~beat_reg];
    assign beat_le   = q_head.le_en && (beat_reg >= q_head.le_start);
    assign beat_last = (beat_reg == q_head.last_idx);

    assign produce = q_not_empty && (!m_valid_reg || m_ready);
    assign q_pop   = produce && beat_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (produce) begin
                beat_reg    <= beat_last ? '0 : beat_reg + BEAT_W'(1);
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            m_sdi_reg  <= beat_sdi;
            m_le_reg   <= beat_le;
            m_last_reg <= beat_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_sdi   = m_sdi_reg;
    assign m_le    = m_le_reg;
    assign m_last  = m_last_reg;

    a_beat_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        q_not_empty |-> (beat_reg <= q_head.last_idx))
        else $error("beat index past end of burst");
    a_beat_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && !beat_last) |=> (beat_reg == $past(beat_reg) + BEAT_W'(1)))
        else $error("beat index did not advance");
    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && beat_last) |=> (beat_reg == '0 && m_valid && m_last))
        else $error("burst end not reflected at output");

endmodule

// ===== rtl/led_driver_le_command_serializer.sv =====
// Serializer for a cascaded constant-current LED driver chain: each accepted command
// other than func 7 becomes a burst of data clocks on m_sdi/m_le, one result per cycle
// while m_ready holds, m_last on the final clock. Data latch and register writes send
// the word MSB first, LE high through the end of the burst on the last chip; vsync,
// pre-active and soft reset hold LE high with SDI low; func 7 is accepted and produces
// nothing. The single-bit output sequencer sets the rate: bursts follow each other
// without gap cycles while the two-entry command queue keeps the input side accepting.
// Depends on lecs_pkg, lecs_front, lecs_queue, lecs_back.
module led_driver_le_command_serializer #(
    parameter int CHAIN_MAX = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lecs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lecs_pkg::WORD_BITS-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lecs_pkg::FUNC_W-1:0]    s_func,
    input  logic [lecs_pkg::WORD_BITS-1:0] s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_sdi,
    output logic                           m_le,
    output logic                           m_last
);
    import lecs_pkg::*;

    logic [CL_W-1:0]      chain_length_reg;
    logic [WORD_BITS-1:0] reg1_word_reg;
    logic [WORD_BITS-1:0] reg2_word_reg;
    logic [WORD_BITS-1:0] reg3_word_reg;

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_not_empty;
    desc_t q_desc;
    desc_t q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_length_reg <= CHAIN_LENGTH_RST;
            reg1_word_reg    <= REG1_WORD_RST;
            reg2_word_reg    <= REG2_WORD_RST;
            reg3_word_reg    <= REG3_WORD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CHAIN_LENGTH: chain_length_reg <= cfg_wdata[CL_W-1:0];
                CFG_REG1_WORD:    reg1_word_reg    <= cfg_wdata;
                CFG_REG2_WORD:    reg2_word_reg    <= cfg_wdata;
                CFG_REG3_WORD:    reg3_word_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lecs_front #(
        .CHAIN_MAX(CHAIN_MAX)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_word       (s_word),
        .chain_length (chain_length_reg),
        .reg1_word    (reg1_word_reg),
        .reg2_word    (reg2_word_reg),
        .reg3_word    (reg3_word_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_desc       (q_desc)
    );

    lecs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    lecs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sdi       (m_sdi),
        .m_le        (m_le),
        .m_last      (m_last)
    );

endmodule
